FILE: rtl/cau_pkg.sv
// Shared definitions for the complex arithmetic unit.
// Holds the operation codes; no dependencies.
package cau_pkg;

   localparam int KIND_WIDTH = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ADD        = 3'd0,
      KIND_SUB        = 3'd1,
      KIND_MUL        = 3'd2,
      KIND_DIV        = 3'd3,
      KIND_CONJ       = 3'd4,
      KIND_NEG        = 3'd5,
      KIND_MAG_SQUARE = 3'd6
   } kind_type;

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: pipelined add, subtract, multiply, divide, conjugate,
// negate and squared magnitude on signed fixed-point complex operands.
// Depends on cau_pkg.
//
// Usage:
//   Drive req_kind and the four operand parts and raise start for one cycle per
//   request. busy stays low: a request is taken in every cycle, back to back.
//   Each result appears on the rsp_ ports for exactly one cycle with rsp_valid
//   high, in request order. Throughput is one request per cycle. The divider
//   resolves one quotient bit per stage over DATA_WIDTH stages; every other
//   operation travels alongside it so results stay in order.
//   Stages: input register, operand products, product sums, rounding and
//   compare with divider setup, DATA_WIDTH divider stages, output register.
//   Reset clears the valid bits of every stage; data registers are not reset
//   and nothing needs a clearing pass. The receiver cannot stall, so the
//   pipeline never holds.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [cau_pkg::KIND_WIDTH-1:0]             req_kind,
   input  logic signed [DATA_WIDTH-1:0]               req_a_re,
   input  logic signed [DATA_WIDTH-1:0]               req_a_im,
   input  logic signed [DATA_WIDTH-1:0]               req_b_re,
   input  logic signed [DATA_WIDTH-1:0]               req_b_im,
   output logic                                       rsp_valid,
   output logic signed [DATA_WIDTH-1:0]               rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]               rsp_res_im,
   output logic [2*DATA_WIDTH-FRAC_BITS-1:0]          rsp_mag_square,
   output logic                                       rsp_is_equal,
   output logic                                       rsp_mag_less,
   output logic                                       rsp_mag_same,
   output logic                                       rsp_saturated,
   output logic                                       rsp_div_zero
);
   import cau_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;
   localparam int MW  = 2 * W;
   localparam int NW  = 2 * W + F;
   localparam int MSW = 2 * W - F;

   localparam logic signed [PW:0] WIDE_MAX   = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW:0] WIDE_MIN   = ~WIDE_MAX;
   localparam logic signed [PW:0] ROUND_HALF = {{PW{1'b0}}, 1'b1} <<< (F-1);
   localparam logic [W-1:0]       VAL_MAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]       VAL_MIN    = {1'b1, {(W-1){1'b0}}};
   localparam logic [W:0]         NEG_LIMIT  = {2'b01, {(W-1){1'b0}}};
   localparam logic [W:0]         POS_LIMIT  = {2'b00, {(W-1){1'b1}}};

   typedef struct packed {
      logic [MW-1:0] rem;
      logic [W-1:0]  low;
      logic [W-1:0]  quo;
      logic          neg;
      logic          ovf;
   } lane_type;

   typedef struct packed {
      logic           is_div;
      logic           dz;
      logic [W-1:0]   res_re;
      logic [W-1:0]   res_im;
      logic           sat;
      logic [MSW-1:0] msq;
      logic           eq;
      logic           less;
      logic           same;
      logic [MW-1:0]  den;
   } meta_type;

   // Clip a wide signed value to the result range: {saturated, value}.
   function automatic logic [W:0] clip_wide(input logic signed [PW:0] x);
      logic [W:0] r;
      if (x > WIDE_MAX)      r = {1'b1, VAL_MAX};
      else if (x < WIDE_MIN) r = {1'b1, VAL_MIN};
      else                   r = {1'b0, x[W-1:0]};
      return r;
   endfunction

   function automatic logic signed [PW:0] widen(input logic signed [W:0] x);
      return {{(PW-W){x[W]}}, x};
   endfunction

   function automatic logic signed [PW:0] widen_prod(input logic signed [PW-1:0] x);
      return {x[PW-1], x};
   endfunction

   // One restoring division step: bring down a dividend bit, subtract if it fits.
   function automatic lane_type div_step(input lane_type l, input logic [MW-1:0] den);
      lane_type   o;
      logic [MW:0] r2;
      logic [MW:0] diff;
      logic        qbit;
      o    = l;
      r2   = {l.rem, l.low[W-1]};
      diff = r2 - {1'b0, den};
      qbit = (r2 >= {1'b0, den});
      o.rem = qbit ? diff[MW-1:0] : r2[MW-1:0];
      o.low = {l.low[W-2:0], 1'b0};
      o.quo = {l.quo[W-2:0], qbit};
      return o;
   endfunction

   // Apply sign and saturate a quotient magnitude: {saturated, value}.
   function automatic logic [W:0] div_finish(input lane_type l);
      logic [W:0] qx;
      logic [W:0] nq;
      logic [W:0] r;
      qx = {1'b0, l.quo};
      nq = ~qx + 1'b1;
      if (l.ovf)                   r = {1'b1, l.neg ? VAL_MIN : VAL_MAX};
      else if (l.neg) begin
         if (qx > NEG_LIMIT)       r = {1'b1, VAL_MIN};
         else                      r = {1'b0, nq[W-1:0]};
      end else begin
         if (qx > POS_LIMIT)       r = {1'b1, VAL_MAX};
         else                      r = {1'b0, qx[W-1:0]};
      end
      return r;
   endfunction

   // Stage 0: input register
   logic                  v0_ff;
   logic [KIND_WIDTH-1:0] kind0_ff;
   logic signed [W-1:0]   ar0_ff, ai0_ff, br0_ff, bi0_ff;

   // Stage 1: products and simple results
   logic                  v1_ff;
   logic [KIND_WIDTH-1:0] kind1_ff;
   logic                  eq1_ff, eq1_in;
   logic [W-1:0]          sre1_ff, sre1_in, sim1_ff, sim1_in;
   logic                  ssat1_ff, ssat1_in;
   logic signed [PW-1:0]  p_rr1_ff, p_ii1_ff, p_ri1_ff, p_ir1_ff;
   logic signed [PW-1:0]  p_aa1_ff, p_ab1_ff, p_ba1_ff, p_bb1_ff;

   // Stage 2: sums of products
   logic                  v2_ff;
   logic [KIND_WIDTH-1:0] kind2_ff;
   logic                  eq2_ff;
   logic [W-1:0]          sre2_ff, sim2_ff;
   logic                  ssat2_ff;
   logic signed [PW:0]    mre2_ff, mre2_in, mim2_ff, mim2_in;
   logic signed [PW:0]    nre2_ff, nre2_in, nim2_ff, nim2_in;
   logic [MW-1:0]         ma2_ff, ma2_in, mb2_ff, mb2_in;

   // Divider stages; entry 0 is loaded by the rounding and setup stage
   logic [W:0]  dvld_ff, dvld_in;
   meta_type    pipe_ff [0:W];
   meta_type    pipe_in [0:W];
   lane_type    re_ff   [0:W];
   lane_type    re_in   [0:W];
   lane_type    im_ff   [0:W];
   lane_type    im_in   [0:W];
   meta_type    meta0_in;
   lane_type    re0_in, im0_in;

   // Output register
   logic           rsp_valid_ff;
   logic [W-1:0]   res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic [MSW-1:0] msq_ff;
   logic           eq_ff, less_ff, same_ff;
   logic           sat_ff, sat_in, dz_ff, dz_in;

   assign busy = 1'b0;

   // Form products and the add, subtract, conjugate and negate results
   always_comb begin
      logic signed [W:0] xar, xai, xbr, xbi;
      logic [W:0]        cr, ci;
      xar = {ar0_ff[W-1], ar0_ff};
      xai = {ai0_ff[W-1], ai0_ff};
      xbr = {br0_ff[W-1], br0_ff};
      xbi = {bi0_ff[W-1], bi0_ff};
      cr  = '0;
      ci  = '0;
      eq1_in = (ar0_ff == br0_ff) && (ai0_ff == bi0_ff);
      unique case (kind_type'(kind0_ff))
         KIND_ADD: begin
            cr = clip_wide(widen(xar + xbr));
            ci = clip_wide(widen(xai + xbi));
         end
         KIND_SUB: begin
            cr = clip_wide(widen(xar - xbr));
            ci = clip_wide(widen(xai - xbi));
         end
         KIND_CONJ: begin
            cr = {1'b0, ar0_ff};
            ci = clip_wide(widen(-xai));
         end
         KIND_NEG: begin
            cr = clip_wide(widen(-xar));
            ci = clip_wide(widen(-xai));
         end
         default: begin
            cr = '0;
            ci = '0;
         end
      endcase
      sre1_in  = cr[W-1:0];
      sim1_in  = ci[W-1:0];
      ssat1_in = cr[W] | ci[W];
   end

   // Sum products into product parts, division numerators and magnitudes
   always_comb begin
      mre2_in = widen_prod(p_rr1_ff) - widen_prod(p_ii1_ff);
      mim2_in = widen_prod(p_ri1_ff) + widen_prod(p_ir1_ff);
      nre2_in = widen_prod(p_rr1_ff) + widen_prod(p_ii1_ff);
      nim2_in = widen_prod(p_ir1_ff) - widen_prod(p_ri1_ff);
      ma2_in  = $unsigned(p_aa1_ff) + $unsigned(p_ab1_ff);
      mb2_in  = $unsigned(p_ba1_ff) + $unsigned(p_bb1_ff);
   end

   // Round products, compare magnitudes, set up both divider lanes
   always_comb begin
      logic signed [PW:0] rnd_re, rnd_im;
      logic [W:0]         mr, mi;
      logic [PW:0]        abs_re, abs_im;
      logic [NW-1:0]      num_re, num_im;
      logic [NW-1:0]      hi_re, hi_im, den_x;
      meta_type           m;
      rnd_re = (mre2_ff + ROUND_HALF) >>> F;
      rnd_im = (mim2_ff + ROUND_HALF) >>> F;
      mr     = clip_wide(rnd_re);
      mi     = clip_wide(rnd_im);
      abs_re = nre2_ff[PW] ? -nre2_ff : nre2_ff;
      abs_im = nim2_ff[PW] ? -nim2_ff : nim2_ff;
      num_re = {abs_re[PW-1:0], {F{1'b0}}};
      num_im = {abs_im[PW-1:0], {F{1'b0}}};
      hi_re  = {{W{1'b0}}, num_re[NW-1:W]};
      hi_im  = {{W{1'b0}}, num_im[NW-1:W]};
      den_x  = {{F{1'b0}}, mb2_ff};

      m.is_div = (kind_type'(kind2_ff) == KIND_DIV);
      m.dz     = m.is_div && (mb2_ff == '0);
      m.eq     = eq2_ff;
      m.less   = ma2_ff < mb2_ff;
      m.same   = ma2_ff == mb2_ff;
      m.den    = mb2_ff;
      m.msq    = '0;
      unique case (kind_type'(kind2_ff))
         KIND_MUL: begin
            m.res_re = mr[W-1:0];
            m.res_im = mi[W-1:0];
            m.sat    = mr[W] | mi[W];
         end
         KIND_MAG_SQUARE: begin
            m.res_re = '0;
            m.res_im = '0;
            m.sat    = 1'b0;
            m.msq    = MSW'(ma2_ff >> F);
         end
         default: begin
            m.res_re = sre2_ff;
            m.res_im = sim2_ff;
            m.sat    = ssat2_ff;
         end
      endcase
      meta0_in = m;

      re0_in.rem = hi_re[MW-1:0];
      re0_in.low = num_re[W-1:0];
      re0_in.quo = '0;
      re0_in.neg = nre2_ff[PW];
      re0_in.ovf = hi_re >= den_x;
      im0_in.rem = hi_im[MW-1:0];
      im0_in.low = num_im[W-1:0];
      im0_in.quo = '0;
      im0_in.neg = nim2_ff[PW];
      im0_in.ovf = hi_im >= den_x;
   end

   // Advance the divider one quotient bit per stage
   always_comb begin
      dvld_in    = {dvld_ff[W-1:0], v2_ff};
      pipe_in[0] = meta0_in;
      re_in[0]   = re0_in;
      im_in[0]   = im0_in;
      for (int k = 1; k <= W; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         re_in[k]   = div_step(re_ff[k-1], pipe_ff[k-1].den);
         im_in[k]   = div_step(im_ff[k-1], pipe_ff[k-1].den);
      end
   end

   // Pick the final result parts
   always_comb begin
      logic [W:0] qr, qi;
      qr        = div_finish(re_ff[W]);
      qi        = div_finish(im_ff[W]);
      res_re_in = pipe_ff[W].res_re;
      res_im_in = pipe_ff[W].res_im;
      sat_in    = pipe_ff[W].sat;
      dz_in     = 1'b0;
      if (pipe_ff[W].is_div) begin
         if (pipe_ff[W].dz) begin
            res_re_in = '0;
            res_im_in = '0;
            sat_in    = 1'b0;
            dz_in     = 1'b1;
         end else begin
            res_re_in = qr[W-1:0];
            res_im_in = qi[W-1:0];
            sat_in    = qr[W] | qi[W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         dvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= start;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= dvld_ff[W];
      end

      kind0_ff <= req_kind;
      ar0_ff   <= req_a_re;
      ai0_ff   <= req_a_im;
      br0_ff   <= req_b_re;
      bi0_ff   <= req_b_im;

      kind1_ff <= kind0_ff;
      eq1_ff   <= eq1_in;
      sre1_ff  <= sre1_in;
      sim1_ff  <= sim1_in;
      ssat1_ff <= ssat1_in;
      p_rr1_ff <= ar0_ff * br0_ff;
      p_ii1_ff <= ai0_ff * bi0_ff;
      p_ri1_ff <= ar0_ff * bi0_ff;
      p_ir1_ff <= ai0_ff * br0_ff;
      p_aa1_ff <= ar0_ff * ar0_ff;
      p_ab1_ff <= ai0_ff * ai0_ff;
      p_ba1_ff <= br0_ff * br0_ff;
      p_bb1_ff <= bi0_ff * bi0_ff;

      kind2_ff <= kind1_ff;
      eq2_ff   <= eq1_ff;
      sre2_ff  <= sre1_ff;
      sim2_ff  <= sim1_ff;
      ssat2_ff <= ssat1_ff;
      mre2_ff  <= mre2_in;
      mim2_ff  <= mim2_in;
      nre2_ff  <= nre2_in;
      nim2_ff  <= nim2_in;
      ma2_ff   <= ma2_in;
      mb2_ff   <= mb2_in;

      pipe_ff <= pipe_in;
      re_ff   <= re_in;
      im_ff   <= im_in;

      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      msq_ff    <= pipe_ff[W].msq;
      eq_ff     <= pipe_ff[W].eq;
      less_ff   <= pipe_ff[W].less;
      same_ff   <= pipe_ff[W].same;
      sat_ff    <= sat_in;
      dz_ff     <= dz_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_re     = res_re_ff;
   assign rsp_res_im     = res_im_ff;
   assign rsp_mag_square = msq_ff;
   assign rsp_is_equal   = eq_ff;
   assign rsp_mag_less   = less_ff;
   assign rsp_mag_same   = same_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_div_zero   = dz_ff;

endmodule
